>>> rtl/multitouch_slot_tracker_unit_assert.svh
// assertion macros used by the slot tracker controller
`ifndef MULTITOUCH_SLOT_TRACKER_UNIT_ASSERT_SVH
`define MULTITOUCH_SLOT_TRACKER_UNIT_ASSERT_SVH
// concurrent check on the rising clock edge, masked during reset
`define MST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same check with no reset mask
`define MST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/mst_pkg.sv
// shared constants and control types of the multitouch slot tracker
package mst_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int NUM_W     = 36;
  localparam int DEN_W     = 17;
  localparam int CNT_W     = 6;

  localparam logic [2:0] OP_SLOT  = 3'd0;
  localparam logic [2:0] OP_TRACK = 3'd1;
  localparam logic [2:0] OP_X     = 3'd2;
  localparam logic [2:0] OP_Y     = 3'd3;
  localparam logic [2:0] OP_MAJOR = 3'd4;
  localparam logic [2:0] OP_SYNC  = 3'd5;

  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_MOTION = 2'd2;

  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_SCR_W  = 3'd4;
  localparam logic [2:0] REG_SCR_H  = 3'd5;
  localparam logic [2:0] REG_P_HIGH = 3'd6;
  localparam logic [2:0] REG_P_LOW  = 3'd7;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic div_wr;
    logic walk_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       needs_div;
    logic       res_here;
    logic       pend_valid;
    logic       out_free;
    logic       idx_last;
    logic       div_done;
  } stat_t;
endpackage

>>> rtl/mst_ctrl.sv
// controller state machine of the multitouch slot tracker
`include "multitouch_slot_tracker_unit_assert.svh"
module mst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mst_pkg::stat_t st,
  output mst_pkg::cmd_t  cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state, state_next;
  logic       adv;

  assign in_ready = (state == S_IDLE);
  assign adv = !st.res_here || !st.pend_valid || st.out_free;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.op == mst_pkg::OP_SYNC) state_next = S_WALK;
        else if (st.needs_div) state_next = S_DIV;
        else state_next = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = S_WR;
      end
      S_WR: begin
        cmd.div_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = adv;
        if (adv && st.idx_last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!st.pend_valid) state_next = S_IDLE;
        else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `MST_ASSERT(a_idle_no_pend, (state == S_IDLE) |-> !st.pend_valid, "pending result left in idle")
  `MST_ASSERT(a_div_to_wr, (state == S_DIV && st.div_done) |=> (state == S_WR), "divide did not end in write")
  `MST_ASSERT(a_flush_done, (state == S_FLUSH && st.out_free) |=> (state == S_IDLE && !st.pend_valid), "flush did not complete")
endmodule

>>> rtl/mst_dp.sv
// datapath of the multitouch slot tracker: registers, slot table, divider, result stages
module mst_dp (
  input  logic                clk,
  input  logic                rst,
  input  mst_pkg::cmd_t       cmd,
  output mst_pkg::stat_t      st,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_wdata,
  input  logic [2:0]          opcode,
  input  logic signed [16:0]  value,
  input  logic [31:0]         time_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          touch_kind,
  output logic [3:0]          slot_index,
  output logic signed [20:0]  pos_x,
  output logic signed [20:0]  pos_y,
  output logic [31:0]         stamp_ms,
  output logic signed [11:0]  pressure_q10,
  output logic                last_of_frame
);
  logic signed [16:0] x_min, x_max, y_min, y_max;
  logic [14:0] scr_w, scr_h;
  logic [15:0] p_high, p_low;

  logic [2:0]         op_r;
  logic signed [16:0] val_r;
  logic [31:0]        time_r;
  logic [mst_pkg::SLOT_W-1:0] cur;

  logic signed [16:0] tid   [mst_pkg::NUM_SLOTS];
  logic signed [20:0] sx    [mst_pkg::NUM_SLOTS];
  logic signed [20:0] sy    [mst_pkg::NUM_SLOTS];
  logic signed [11:0] pres  [mst_pkg::NUM_SLOTS];
  logic [mst_pkg::NUM_SLOTS-1:0] chg, mov, dwn;

  logic [mst_pkg::NUM_W-1:0] quo;
  logic [mst_pkg::DEN_W:0]   rem;
  logic [mst_pkg::DEN_W-1:0] den;
  logic [mst_pkg::CNT_W-1:0] cnt;

  logic [mst_pkg::SLOT_W-1:0] idx;
  logic       pend_valid;
  logic [1:0] pend_kind;
  logic [3:0] pend_slot;
  logic signed [20:0] pend_x, pend_y;
  logic signed [11:0] pend_p;

  // operand selection for the scale or pressure division
  logic signed [18:0] lo_s, hi_s, span_s, diff_s, c_s, v19;
  logic [18:0] mult;
  logic x_degen, y_degen, p_none;
  logic [mst_pkg::DEN_W:0] trial;
  logic [mst_pkg::DEN_W:0] trial_sub;
  logic out_free, push;

  // walk evaluation
  logic w_down, w_up, w_motion, res_here;
  logic [1:0] w_kind;

  assign v19 = {{2{val_r[16]}}, val_r};
  assign x_degen = (x_max <= x_min);
  assign y_degen = (y_max <= y_min);
  assign p_none  = (p_high == 16'd0);

  always_comb begin
    lo_s = {{2{x_min[16]}}, x_min};
    hi_s = {{2{x_max[16]}}, x_max};
    mult = {scr_w, 4'b0};
    unique case (op_r)
      mst_pkg::OP_Y: begin
        lo_s = {{2{y_min[16]}}, y_min};
        hi_s = {{2{y_max[16]}}, y_max};
        mult = {scr_h, 4'b0};
      end
      mst_pkg::OP_MAJOR: begin
        lo_s = {3'b0, p_low};
        hi_s = (p_high <= p_low) ? ({3'b0, p_low} + 19'sd1) : {3'b0, p_high};
        mult = 19'd1024;
      end
      default: ;
    endcase
    span_s = hi_s - lo_s;
    diff_s = v19 - lo_s;
    if (diff_s < 0) c_s = '0;
    else if (diff_s > span_s) c_s = span_s;
    else c_s = diff_s;
  end

  always_comb begin
    unique case (op_r)
      mst_pkg::OP_X:     st.needs_div = !x_degen;
      mst_pkg::OP_Y:     st.needs_div = !y_degen;
      mst_pkg::OP_MAJOR: st.needs_div = !p_none;
      default:           st.needs_div = 1'b0;
    endcase
  end

  assign trial     = {rem[mst_pkg::DEN_W-1:0], quo[mst_pkg::NUM_W-1]};
  assign trial_sub = trial - {1'b0, den};

  assign w_down   = chg[idx] && !tid[idx][16] && !dwn[idx];
  assign w_up     = chg[idx] && tid[idx][16] && dwn[idx];
  assign w_motion = !w_down && !w_up && dwn[idx] && mov[idx];
  assign res_here = w_down || w_up || w_motion;
  assign w_kind   = w_down ? mst_pkg::KIND_DOWN : (w_up ? mst_pkg::KIND_UP : mst_pkg::KIND_MOTION);

  assign out_free = !out_valid || out_ready;
  assign push = (cmd.walk_step && res_here && pend_valid) || cmd.flush;

  assign st.op         = op_r;
  assign st.res_here   = res_here;
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;
  assign st.idx_last   = (idx == mst_pkg::SLOT_W'(mst_pkg::NUM_SLOTS - 1));
  assign st.div_done   = (cnt == mst_pkg::CNT_W'(mst_pkg::NUM_W - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= 17'sd0;  x_max <= 17'sd4095;
      y_min <= 17'sd0;  y_max <= 17'sd4095;
      scr_w <= 15'd1920; scr_h <= 15'd1080;
      p_high <= 16'd0;  p_low <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mst_pkg::REG_X_MIN:  x_min  <= cfg_wdata;
        mst_pkg::REG_X_MAX:  x_max  <= cfg_wdata;
        mst_pkg::REG_Y_MIN:  y_min  <= cfg_wdata;
        mst_pkg::REG_Y_MAX:  y_max  <= cfg_wdata;
        mst_pkg::REG_SCR_W:  scr_w  <= cfg_wdata[14:0];
        mst_pkg::REG_SCR_H:  scr_h  <= cfg_wdata[14:0];
        mst_pkg::REG_P_HIGH: p_high <= cfg_wdata[15:0];
        mst_pkg::REG_P_LOW:  p_low  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input capture and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      val_r  <= value;
      time_r <= time_ms;
    end
    if (cmd.exec && st.needs_div) begin
      quo <= c_s[16:0] * mult;
      den <= span_s[16:0];
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial_sub;
        quo <= {quo[mst_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[mst_pkg::NUM_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  // slot table, walk index and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      idx <= '0;
      pend_valid <= 1'b0;
      chg <= '0; mov <= '0; dwn <= '0;
      for (int i = 0; i < mst_pkg::NUM_SLOTS; i++) begin
        tid[i]  <= -17'sd1;
        sx[i]   <= '0;
        sy[i]   <= '0;
        pres[i] <= -12'sd1;
      end
    end else begin
      if (cmd.exec) begin
        unique case (op_r)
          mst_pkg::OP_SLOT:
            if (!val_r[16] && val_r[15:mst_pkg::SLOT_W] == '0) cur <= val_r[mst_pkg::SLOT_W-1:0];
          mst_pkg::OP_TRACK: begin
            tid[cur] <= val_r;
            chg[cur] <= 1'b1;
          end
          mst_pkg::OP_X:
            if (x_degen) begin
              sx[cur]  <= {val_r, 4'b0};
              mov[cur] <= 1'b1;
            end
          mst_pkg::OP_Y:
            if (y_degen) begin
              sy[cur]  <= {val_r, 4'b0};
              mov[cur] <= 1'b1;
            end
          mst_pkg::OP_MAJOR:
            if (p_none) pres[cur] <= -12'sd1;
          mst_pkg::OP_SYNC: begin
            idx <= '0;
            pend_valid <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.div_wr) begin
        unique case (op_r)
          mst_pkg::OP_X: begin
            sx[cur]  <= quo[20:0];
            mov[cur] <= 1'b1;
          end
          mst_pkg::OP_Y: begin
            sy[cur]  <= quo[20:0];
            mov[cur] <= 1'b1;
          end
          default: pres[cur] <= quo[11:0];
        endcase
      end
      if (cmd.walk_step) begin
        chg[idx] <= 1'b0;
        mov[idx] <= 1'b0;
        if (w_down) dwn[idx] <= 1'b1;
        if (w_up) begin
          dwn[idx]  <= 1'b0;
          pres[idx] <= -12'sd1;
        end
        if (res_here) begin
          pend_valid <= 1'b1;
          pend_kind  <= w_kind;
          pend_slot  <= 4'(idx);
          pend_x     <= sx[idx];
          pend_y     <= sy[idx];
          pend_p     <= pres[idx];
        end
        idx <= idx + 1'b1;
      end
      if (cmd.flush) pend_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (push) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (push) begin
      touch_kind    <= pend_kind;
      slot_index    <= pend_slot;
      pos_x         <= pend_x;
      pos_y         <= pend_y;
      pressure_q10  <= pend_p;
      stamp_ms      <= time_r;
      last_of_frame <= cmd.flush;
    end
  end
endmodule

>>> rtl/multitouch_slot_tracker_unit.sv
// top level of the multitouch slot tracker: controller plus datapath
// slot select, tracking id and ignored items go straight back to idle for the next item
// x, y and contact size items run the 36-step shift-subtract divider and then write back,
// or skip the divider on a degenerate range or with no pressure data
// frame sync walks all 16 slots and then flushes the held result, stalling while results stall
// synchronous active-high reset restores register defaults and clears the whole slot table
module multitouch_slot_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [16:0] value,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         touch_kind,
  output logic [3:0]         slot_index,
  output logic signed [20:0] pos_x,
  output logic signed [20:0] pos_y,
  output logic [31:0]        stamp_ms,
  output logic signed [11:0] pressure_q10,
  output logic               last_of_frame
);
  // command and status between the two halves
  mst_pkg::cmd_t  cmd;
  mst_pkg::stat_t st;

  // results leave through an output register, one pending result held to mark the last one

  // sequencing: item capture, divide steps, slot walk
  mst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // register file, slot table, divider and result stages
  mst_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .opcode        (opcode),
    .value         (value),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .touch_kind    (touch_kind),
    .slot_index    (slot_index),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .stamp_ms      (stamp_ms),
    .pressure_q10  (pressure_q10),
    .last_of_frame (last_of_frame)
  );
endmodule
